FILE: hdl/icmphd_pkg.sv
// Shared types and constants for the ICMPv4 header decoder.
// No dependencies; imported by every module of the block.
package icmphd_pkg;

  localparam int HDR_LEN    = 8;
  localparam int IP_HDR_LEN = 20;
  localparam int EMB_KEEP   = 24;
  localparam int OUT_TDATA_W = 200;

  // event_flags bit positions
  localparam int EV_SMALL  = 0;
  localparam int EV_TYPE   = 1;
  localparam int EV_CODE   = 2;
  localparam int EV_TRUNC  = 3;
  localparam int EV_VER    = 4;
  localparam int EV_REJECT = 5;

  // ICMP types
  localparam logic [7:0] TY_ECHO_REPLY = 8'd0;
  localparam logic [7:0] TY_UNREACH    = 8'd3;
  localparam logic [7:0] TY_QUENCH     = 8'd4;
  localparam logic [7:0] TY_REDIRECT   = 8'd5;
  localparam logic [7:0] TY_ECHO_REQ   = 8'd8;
  localparam logic [7:0] TY_ROUTER_ADV = 8'd9;
  localparam logic [7:0] TY_TIME_EXC   = 8'd11;
  localparam logic [7:0] TY_PARAM_PROB = 8'd12;
  localparam logic [7:0] TY_TSTAMP_REQ = 8'd13;
  localparam logic [7:0] TY_TSTAMP_REP = 8'd14;
  localparam logic [7:0] TY_INFO_REQ   = 8'd15;
  localparam logic [7:0] TY_INFO_REP   = 8'd16;
  localparam logic [7:0] TY_MASK_REQ   = 8'd17;
  localparam logic [7:0] TY_MASK_REP   = 8'd18;

  // embedded protocols
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VERSION = 4'd4;

  typedef enum logic [1:0] {
    CFG_UNREACH  = 2'd0,
    CFG_REDIRECT = 2'd1,
    CFG_TIME_EXC = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] unreach;
    logic [7:0] redirect;
    logic [7:0] time_exc;
  } cfg_t;

  // captured message bytes, index 0 in the lowest bits
  typedef struct packed {
    logic [EMB_KEEP-1:0][7:0] emb;
    logic [HDR_LEN-1:0][7:0]  head;
  } snap_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] emb_dst_port;
    logic [15:0] emb_src_port;
    logic [7:0]  emb_proto;
    logic [31:0] emb_dst;
    logic [31:0] emb_src;
    logic [5:0]  event_flags;
    logic [16:0] body_len;
    logic [17:0] header_len;
    logic [15:0] sequence_res;
    logic [15:0] ident;
    logic [7:0]  msg_code;
    logic [7:0]  msg_type;
  } result_t;

endpackage

FILE: hdl/icmphd_capture.sv
// Input register, saturating byte count and header/embedded byte store.
// Hands a snapshot of the message to the decoder on the last beat. Uses icmphd_pkg.
module icmphd_capture #(
  parameter int COUNT_LIMIT = 131071
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output logic [$clog2(COUNT_LIMIT+1)-1:0] snap_len,
  output icmphd_pkg::snap_t     snap
);
  import icmphd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

  logic             a_valid_r;
  logic [7:0]       a_data_r;
  logic             a_last_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] len_nxt;
  logic [HDR_LEN-1:0][7:0]  head_r;
  logic [HDR_LEN-1:0][7:0]  head_nxt;
  logic [EMB_KEEP-1:0][7:0] emb_r;
  logic [EMB_KEEP-1:0][7:0] emb_nxt;
  logic             snap_valid_r;
  logic [CNT_W-1:0] snap_len_r;
  snap_t            snap_r;
  logic             consume;

  // non-last beats never wait; a last beat needs the snapshot slot
  assign consume   = a_valid_r && (!a_last_r || !snap_valid_r || snap_ready);
  assign in_tready = !a_valid_r || consume;

  assign len_nxt = (count_r < CNT_W'(COUNT_LIMIT)) ? count_r + CNT_W'(1)
                                                   : CNT_W'(COUNT_LIMIT);

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      head_nxt[i] = (count_r == CNT_W'(i)) ? a_data_r : head_r[i];
    end
    for (int i = 0; i < EMB_KEEP; i++) begin
      emb_nxt[i] = (count_r == CNT_W'(HDR_LEN + i)) ? a_data_r : emb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      a_data_r <= in_tdata;
      a_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (consume) begin
      count_r <= a_last_r ? '0 : len_nxt;
    end
    if (consume) begin
      head_r <= head_nxt;
      emb_r  <= emb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (consume && a_last_r) begin
      snap_valid_r <= 1'b1;
    end else if (snap_ready) begin
      snap_valid_r <= 1'b0;
    end
    if (consume && a_last_r) begin
      snap_len_r  <= len_nxt;
      snap_r.head <= head_nxt;
      snap_r.emb  <= emb_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_len   = snap_len_r;
  assign snap       = snap_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(COUNT_LIMIT))
    else $error("byte count above limit");

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    consume && a_last_r |=> count_r == '0)
    else $error("byte count not cleared after last beat");

  a_only_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !consume |-> a_last_r && snap_valid_r && !snap_ready)
    else $error("input beat held without cause");
`endif

endmodule

FILE: hdl/icmphd_decode.sv
// Decode of one captured message into a result, and the result register.
// Uses icmphd_pkg; fed by icmphd_capture.
module icmphd_decode #(
  parameter int COUNT_LIMIT = 131071
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  logic [$clog2(COUNT_LIMIT+1)-1:0] snap_len,
  input  icmphd_pkg::snap_t     snap,
  input  icmphd_pkg::cfg_t      cfg,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [icmphd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import icmphd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int DW    = ((CNT_W > 18) ? CNT_W : 18) + 1;

  logic          out_valid_r;
  result_t       res_r;
  result_t       res;
  logic [DW-1:0] len_x;
  logic [DW-1:0] elen;
  logic [DW-1:0] diff;
  logic [15:0]   adv_prod;
  logic [17:0]   alen;
  logic [17:0]   hlen;
  logic [5:0]    ev;
  logic [7:0]    ty;
  logic [7:0]    cd;
  logic [7:0]    limit;
  logic [7:0]    proto;
  logic          query;
  logic          limited;
  logic          embed;
  logic          always_emb;

  assign len_x    = DW'(snap_len);
  assign ty       = snap.head[0];
  assign cd       = snap.head[1];
  assign proto    = snap.emb[9];
  assign adv_prod = snap.head[4] * snap.head[5];
  assign alen     = {adv_prod, 2'b00};
  assign diff     = len_x - DW'(hlen);
  assign elen     = len_x - DW'(HDR_LEN);

  always_comb begin
    res        = '0;
    ev         = '0;
    hlen       = 18'd8;
    query      = 1'b0;
    limited    = 1'b0;
    embed      = 1'b0;
    always_emb = 1'b0;
    limit      = '0;
    if (len_x < DW'(HDR_LEN)) begin
      res.event_flags = 6'(1 << EV_SMALL) | 6'(1 << EV_REJECT);
    end else begin
      res.msg_type = ty;
      res.msg_code = cd;
      case (ty)
        TY_ECHO_REPLY, TY_ECHO_REQ, TY_INFO_REQ, TY_INFO_REP, TY_MASK_REQ,
        TY_MASK_REP: begin
          query = 1'b1;
        end
        TY_TSTAMP_REQ, TY_TSTAMP_REP: begin
          query = 1'b1;
          if (len_x < DW'(HDR_LEN + 12)) ev[EV_TRUNC] = 1'b1;
          else hlen = 18'd20;
        end
        TY_UNREACH: begin
          limited = 1'b1;
          limit   = cfg.unreach;
          embed   = 1'b1;
        end
        TY_QUENCH: begin
          embed      = 1'b1;
          always_emb = 1'b1;
        end
        TY_REDIRECT: begin
          limited = 1'b1;
          limit   = cfg.redirect;
          embed   = 1'b1;
        end
        TY_TIME_EXC: begin
          limited = 1'b1;
          limit   = cfg.time_exc;
          embed   = 1'b1;
        end
        TY_PARAM_PROB: begin
          embed = 1'b1;
        end
        TY_ROUTER_ADV: begin
          if (len_x < DW'(alen) + DW'(HDR_LEN)) ev[EV_TRUNC] = 1'b1;
          else hlen = alen + 18'd8;
        end
        default: begin
          ev[EV_TYPE] = 1'b1;
        end
      endcase

      // router advertisement and unknown types skip the code check
      if (ty != TY_ROUTER_ADV && !ev[EV_TYPE]) begin
        if (limited ? (cd > limit) : (cd != 8'd0)) begin
          ev[EV_CODE] = 1'b1;
          embed       = 1'b0;
        end
      end

      if (query) begin
        res.ident        = {snap.head[4], snap.head[5]};
        res.sequence_res = {snap.head[6], snap.head[7]};
      end

      if (embed && (always_emb || len_x > DW'(HDR_LEN))) begin
        if (ty != TY_UNREACH && len_x > DW'(HDR_LEN + 65535)) begin
          ev[EV_REJECT] = 1'b1;
        end else if (elen < DW'(IP_HDR_LEN)) begin
          ev[EV_TRUNC] = 1'b1;
        end else if (snap.emb[0][7:4] != IP_VERSION) begin
          ev[EV_VER] = 1'b1;
        end else begin
          res.emb_src = {snap.emb[12], snap.emb[13], snap.emb[14], snap.emb[15]};
          res.emb_dst = {snap.emb[16], snap.emb[17], snap.emb[18], snap.emb[19]};
          if ((proto == PROTO_TCP && elen >= DW'(IP_HDR_LEN + 4)) ||
              (proto == PROTO_UDP && elen >= DW'(IP_HDR_LEN + 8))) begin
            res.emb_proto    = proto;
            res.emb_src_port = {snap.emb[20], snap.emb[21]};
            res.emb_dst_port = {snap.emb[22], snap.emb[23]};
          end else if (proto == PROTO_ICMP && elen >= DW'(IP_HDR_LEN + 8)) begin
            res.emb_proto = PROTO_ICMP;
          end
        end
      end

      res.header_len  = hlen;
      res.body_len    = ev[EV_REJECT] ? 17'd0 : diff[16:0];
      res.event_flags = ev;
    end
  end

  assign snap_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

`ifndef NO_ASSERTIONS
  a_reject_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.event_flags[EV_REJECT] |-> res_r.body_len == 17'd0)
    else $error("payload length on a rejected message");

  a_small_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.event_flags[EV_SMALL]
      |-> res_r.header_len == 18'd0 && res_r.msg_type == 8'd0 && res_r.emb_src == 32'd0)
    else $error("fields set on a too-small message");

  a_ports_need_proto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.emb_proto == 8'd0
      |-> res_r.emb_src_port == 16'd0 && res_r.emb_dst_port == 16'd0)
    else $error("embedded ports without protocol");
`endif

endmodule

FILE: hdl/icmpv4_header_decoder.sv
// Top level of the ICMPv4 header decoder: configuration registers, capture and decode.
// Depends on icmphd_pkg, icmphd_capture and icmphd_decode.
//
//  channel | dir | beat carries                       | handshake
//  in_     | in  | one message byte, tlast on last    | in_tvalid / in_tready
//  out_    | out | one decode result per message      | out_tvalid / out_tready
//  cfg_    | in  | register index and 8-bit limit     | cfg_valid / cfg_ready
//
// One byte per cycle sustained unless a last byte waits for the snapshot slot; out_tvalid
// rises once the last byte has passed the input beat and message snapshot registers.
// Three register stages: input beat, message snapshot, result; each stalls only
// when the next one is full, so bytes keep flowing while a result waits.
// Synchronous active-low reset clears counts and valids and loads the default limits.
// cfg_ready is always high.
module icmpv4_header_decoder #(
  parameter int COUNT_LIMIT = 131071
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] msg_type, [15:8] msg_code, [31:16] ident, [47:32] sequence_res,
  // [65:48] header_len, [82:66] body length, [88:83] event_flags,
  // [120:89] emb_src, [152:121] emb_dst, [160:153] emb_proto,
  // [176:161] embedded source port, [192:177] embedded destination port, [199:193] zero
  output logic [icmphd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import icmphd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

  cfg_t             cfg_r;
  logic             snap_valid;
  logic             snap_ready;
  logic [CNT_W-1:0] snap_len;
  snap_t            snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unreach  <= 8'd15;
      cfg_r.redirect <= 8'd3;
      cfg_r.time_exc <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UNREACH:  cfg_r.unreach  <= cfg_data;
        CFG_REDIRECT: cfg_r.redirect <= cfg_data;
        CFG_TIME_EXC: cfg_r.time_exc <= cfg_data;
        default: ;
      endcase
    end
  end

  icmphd_capture #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_len   (snap_len),
    .snap       (snap)
  );

  icmphd_decode #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_len   (snap_len),
    .snap       (snap),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
